### src/gpf_pkg.sv
// Package for the gravitational pair force pipeline.
// Holds the field widths and the sideband type shared by all stages.
// No dependencies.
package gpf_pkg;

	localparam int CoordW = 32;
	localparam int NumW   = 128;
	localparam int DenW   = 100;
	localparam int RemW   = 133;
	localparam int QuoW   = 32;
	localparam int Lanes  = 3;

	// Values that ride along with the square root until the division needs them.
	typedef struct packed {
		logic [Lanes-1:0][NumW-1:0] num;
		logic [Lanes-1:0]           neg;
		logic                       coinc;
	} gpf_side_t;

endpackage

### src/gravitational_pair_force.sv
// Gravitational pair force, top level: G register, pipeline chain and output skid.
// Depends on gpf_pkg, gpf_front, gpf_isqrt and gpf_div.
//
// Usage: each item on the s_ channel is a pair of bodies (positions and masses).
// One item on the m_ channel returns the force on the first body from the second,
// plus coincident and clipped flags. G is written on the cfg_ channel, which is
// always ready; write it only while no item is in flight.
// Throughput: one item per cycle while the skid register is empty. Latency: 75 register
// stages (5 front, 32 square root, 37 divider, 1 output).
// Reset clears all valid bits and loads G with 1.0 in the chosen fixed-point format.
// When the receiver stalls, one extra item lands in a skid register; after that
// the whole pipeline holds and s_tready drops until the skid drains.
// No item is lost or repeated.
module gravitational_pair_force
	import gpf_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [31:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// first_x, first_y, first_z, first_mass, second_x, second_y, second_z, second_mass
	input  logic [255:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// force_x, force_y, force_z
	output logic [95:0]  m_tdata,
	// coincident, clipped
	output logic [1:0]   m_tuser
);

	logic [31:0] g_q;
	logic        en;

	logic        fr_valid;
	logic [63:0] fr_sum;
	logic [1:0]  fr_k;
	gpf_side_t   fr_side;

	logic        sq_valid;
	logic [63:0] sq_sum;
	logic [31:0] sq_root;
	logic [1:0]  sq_k;
	gpf_side_t   sq_side;

	logic                   dv_valid;
	logic [Lanes-1:0][31:0] dv_force;
	logic                   dv_coinc, dv_clip;
	logic                   push;

	logic        out_v_q, skid_v_q;
	logic [95:0] out_data_q, skid_data_q;
	logic [1:0]  out_user_q, skid_user_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			g_q <= 32'(64'd1 << FRAC_BITS);
		end else if (cfg_valid) begin
			g_q <= cfg_data;
		end
	end

	assign en       = ~skid_v_q;
	assign s_tready = en;
	assign push     = en & dv_valid;

	gpf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.g_const   (g_q),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata),
		.out_valid (fr_valid),
		.out_sum   (fr_sum),
		.out_k     (fr_k),
		.out_side  (fr_side)
	);

	gpf_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_valid),
		.in_sum    (fr_sum),
		.in_k      (fr_k),
		.in_side   (fr_side),
		.out_valid (sq_valid),
		.out_sum   (sq_sum),
		.out_root  (sq_root),
		.out_k     (sq_k),
		.out_side  (sq_side)
	);

	gpf_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_valid),
		.in_sum    (sq_sum),
		.in_root   (sq_root),
		.in_k      (sq_k),
		.in_side   (sq_side),
		.out_valid (dv_valid),
		.out_force (dv_force),
		.out_coinc (dv_coinc),
		.out_clip  (dv_clip)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_data_q <= skid_data_q;
				out_user_q <= skid_user_q;
			end else begin
				out_data_q <= dv_force;
				out_user_q <= {dv_clip, dv_coinc};
			end
		end else if (push) begin
			skid_data_q <= dv_force;
			skid_user_q <= {dv_clip, dv_coinc};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;

endmodule

### src/gpf_front.sv
// Front of the pipeline: axis differences, range scaling, products and numerators.
// Five register stages. Depends on gpf_pkg.
module gpf_front
	import gpf_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [31:0]       g_const,
	input  logic              in_valid,
	input  logic [255:0]      in_data,
	output logic              out_valid,
	output logic [63:0]       out_sum,
	output logic [1:0]        out_k,
	output gpf_side_t         out_side
);

	logic        [32:0] mag_c [Lanes];
	logic        [Lanes-1:0] neg_c;
	logic        [32:0] max_c;
	logic        [1:0]  k_c;
	logic        [30:0] a_c [Lanes];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [32:0]      mag_s1 [Lanes];
	logic [Lanes-1:0] neg_s1;
	logic [31:0]      m1_s1, m2_s1;

	logic [30:0]      a_s2 [Lanes];
	logic [1:0]       k_s2;
	logic [Lanes-1:0] neg_s2;
	logic             coinc_s2;
	logic [31:0]      m1_s2, m2_s2;

	logic [61:0]      sq_s3 [Lanes];
	logic [63:0]      gm_s3;
	logic [63:0]      ma_s3 [Lanes];
	logic [1:0]       k_s3;
	logic [Lanes-1:0] neg_s3;
	logic             coinc_s3;

	logic [63:0]      sum_s4;
	logic [63:0]      pll_s4 [Lanes];
	logic [63:0]      plh_s4 [Lanes];
	logic [63:0]      phl_s4 [Lanes];
	logic [63:0]      phh_s4 [Lanes];
	logic [1:0]       k_s4;
	logic [Lanes-1:0] neg_s4;
	logic             coinc_s4;

	logic [63:0]      sum_s5;
	logic [1:0]       k_s5;
	gpf_side_t        side_s5;

	always_comb begin
		logic signed [32:0] f, s, d;
		for (int i = 0; i < Lanes; i++) begin
			f = {in_data[i*CoordW+31], in_data[i*CoordW +: CoordW]};
			s = {in_data[(i+4)*CoordW+31], in_data[(i+4)*CoordW +: CoordW]};
			d = s - f;
			neg_c[i] = d[32];
			mag_c[i] = d[32] ? 33'(-d) : 33'(d);
		end
	end

	// Scale down so that every scaled difference fits in 31 bits.
	always_comb begin
		max_c = mag_s1[0];
		for (int i = 1; i < Lanes; i++) begin
			if (mag_s1[i] > max_c) begin
				max_c = mag_s1[i];
			end
		end
		k_c = max_c[32] ? 2'd2 : (max_c[31] ? 2'd1 : 2'd0);
		for (int i = 0; i < Lanes; i++) begin
			a_c[i] = 31'(mag_s1[i] >> k_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Lanes; i++) begin
				mag_s1[i] <= mag_c[i];
			end
			neg_s1 <= neg_c;
			m1_s1  <= in_data[3*CoordW +: CoordW];
			m2_s1  <= in_data[7*CoordW +: CoordW];

			for (int i = 0; i < Lanes; i++) begin
				a_s2[i] <= a_c[i];
			end
			k_s2     <= k_c;
			neg_s2   <= neg_s1;
			coinc_s2 <= (mag_s1[0] == 33'd0) && (mag_s1[1] == 33'd0) && (mag_s1[2] == 33'd0);
			m1_s2    <= m1_s1;
			m2_s2    <= m2_s1;

			for (int i = 0; i < Lanes; i++) begin
				sq_s3[i] <= {31'd0, a_s2[i]} * {31'd0, a_s2[i]};
				ma_s3[i] <= {32'd0, m2_s2} * {33'd0, a_s2[i]};
			end
			gm_s3    <= {32'd0, g_const} * {32'd0, m1_s2};
			k_s3     <= k_s2;
			neg_s3   <= neg_s2;
			coinc_s3 <= coinc_s2;

			sum_s4 <= 64'(sq_s3[0]) + 64'(sq_s3[1]) + 64'(sq_s3[2]);
			for (int i = 0; i < Lanes; i++) begin
				pll_s4[i] <= {32'd0, gm_s3[31:0]} * {32'd0, ma_s3[i][31:0]};
				plh_s4[i] <= {32'd0, gm_s3[31:0]} * {32'd0, ma_s3[i][63:32]};
				phl_s4[i] <= {32'd0, gm_s3[63:32]} * {32'd0, ma_s3[i][31:0]};
				phh_s4[i] <= {32'd0, gm_s3[63:32]} * {32'd0, ma_s3[i][63:32]};
			end
			k_s4     <= k_s3;
			neg_s4   <= neg_s3;
			coinc_s4 <= coinc_s3;

			sum_s5 <= sum_s4;
			k_s5   <= k_s4;
			for (int i = 0; i < Lanes; i++) begin
				side_s5.num[i] <= {64'd0, pll_s4[i]} + {32'd0, plh_s4[i], 32'd0}
					+ {32'd0, phl_s4[i], 32'd0} + {phh_s4[i], 64'd0};
			end
			side_s5.neg   <= neg_s4;
			side_s5.coinc <= coinc_s4;
		end
	end

	assign out_valid = v_s5;
	assign out_sum   = sum_s5;
	assign out_k     = k_s5;
	assign out_side  = side_s5;

endmodule

### src/gpf_isqrt.sv
// Pipelined integer square root of the 64-bit sum of squares, one result bit a stage.
// Carries the scale shift and the sideband alongside. Depends on gpf_pkg.
module gpf_isqrt
	import gpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  logic [63:0] in_sum,
	input  logic [1:0]  in_k,
	input  gpf_side_t in_side,
	output logic      out_valid,
	output logic [63:0] out_sum,
	output logic [31:0] out_root,
	output logic [1:0]  out_k,
	output gpf_side_t out_side
);

	localparam int Steps = 32;

	logic        v_s    [0:Steps];
	logic [63:0] rad_s  [0:Steps];
	logic [63:0] root_s [0:Steps];
	logic [63:0] sum_s  [0:Steps];
	logic [1:0]  k_s    [0:Steps];
	gpf_side_t   side_s [0:Steps];

	assign v_s[0]    = in_valid;
	assign rad_s[0]  = in_sum;
	assign root_s[0] = 64'd0;
	assign sum_s[0]  = in_sum;
	assign k_s[0]    = in_k;
	assign side_s[0] = in_side;

	for (genvar j = 0; j < Steps; j++) begin : g_step
		localparam int Sh = 62 - 2*j;
		logic [63:0] trial;
		assign trial = root_s[j] + (64'd1 << Sh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rad_s[j] >= trial) begin
					rad_s[j+1]  <= rad_s[j] - trial;
					root_s[j+1] <= (root_s[j] >> 1) + (64'd1 << Sh);
				end else begin
					rad_s[j+1]  <= rad_s[j];
					root_s[j+1] <= root_s[j] >> 1;
				end
				sum_s[j+1]  <= sum_s[j];
				k_s[j+1]    <= k_s[j];
				side_s[j+1] <= side_s[j];
			end
		end
	end

	assign out_valid = v_s[Steps];
	assign out_sum   = sum_s[Steps];
	assign out_root  = root_s[Steps][31:0];
	assign out_k     = k_s[Steps];
	assign out_side  = side_s[Steps];

endmodule

### src/gpf_div.sv
// Divider back end: denominator S*t*4^k, a 33-step restoring divide per axis and
// saturation. The top quotient step detects overflow. Depends on gpf_pkg.
module gpf_div
	import gpf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      in_valid,
	input  logic [63:0] in_sum,
	input  logic [31:0] in_root,
	input  logic [1:0]  in_k,
	input  gpf_side_t in_side,
	output logic      out_valid,
	output logic [Lanes-1:0][31:0] out_force,
	output logic      out_coinc,
	output logic      out_clip
);

	localparam int Steps = QuoW + 1;

	logic        v_d1, v_d2;
	logic [63:0] plo_d1, phi_d1;
	logic [1:0]  k_d1, k_d2;
	gpf_side_t   side_d1, side_d2;
	logic [95:0] den_d2;

	logic                       v_s    [0:Steps];
	logic [DenW-1:0]            den_s  [0:Steps];
	logic [Lanes-1:0][NumW-1:0] rem_s  [0:Steps];
	logic [Lanes-1:0][Steps-1:0] q_s   [0:Steps];
	logic [Lanes-1:0]           neg_s  [0:Steps];
	logic                       coinc_s [0:Steps];

	logic                        v_f;
	logic [Lanes-1:0][31:0]      force_f;
	logic                        coinc_f, clip_f;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1   <= 1'b0;
			v_d2   <= 1'b0;
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_d1   <= in_valid;
			v_d2   <= v_d1;
			v_s[0] <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_d1  <= {32'd0, in_sum[31:0]} * {32'd0, in_root};
			phi_d1  <= {32'd0, in_sum[63:32]} * {32'd0, in_root};
			k_d1    <= in_k;
			side_d1 <= in_side;

			den_d2  <= {32'd0, plo_d1} + {phi_d1, 32'd0};
			k_d2    <= k_d1;
			side_d2 <= side_d1;

			den_s[0]   <= {4'd0, den_d2} << {k_d2, 1'b0};
			rem_s[0]   <= side_d2.num;
			q_s[0]     <= '0;
			neg_s[0]   <= side_d2.neg;
			coinc_s[0] <= side_d2.coinc;
		end
	end

	// Step j decides quotient bit QuoW-j; the first step's bit means overflow.
	for (genvar j = 0; j < Steps; j++) begin : g_step
		localparam int Sh = QuoW - j;
		logic [RemW-1:0]  dsh;
		logic [Lanes-1:0] ge;
		assign dsh = {{(RemW-DenW){1'b0}}, den_s[j]} << Sh;

		always_comb begin
			for (int i = 0; i < Lanes; i++) begin
				ge[i] = {{(RemW-NumW){1'b0}}, rem_s[j][i]} >= dsh;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j+1] <= 1'b0;
			end else if (en) begin
				v_s[j+1] <= v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < Lanes; i++) begin
					rem_s[j+1][i] <= ge[i] ? NumW'({{(RemW-NumW){1'b0}}, rem_s[j][i]} - dsh)
						: rem_s[j][i];
					q_s[j+1][i] <= {q_s[j][i][Steps-2:0], ge[i]};
				end
				den_s[j+1]   <= den_s[j];
				neg_s[j+1]   <= neg_s[j];
				coinc_s[j+1] <= coinc_s[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_f <= 1'b0;
		end else if (en) begin
			v_f <= v_s[Steps];
		end
	end

	always_ff @(posedge clk) begin
		logic [31:0] lim, mag;
		logic        over, any_clip;
		if (en) begin
			any_clip = 1'b0;
			for (int i = 0; i < Lanes; i++) begin
				lim  = neg_s[Steps][i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
				over = q_s[Steps][i][QuoW] || (q_s[Steps][i][QuoW-1:0] > lim);
				mag  = over ? lim : q_s[Steps][i][QuoW-1:0];
				if (coinc_s[Steps]) begin
					force_f[i] <= 32'd0;
				end else begin
					force_f[i] <= neg_s[Steps][i] ? 32'(-mag) : mag;
				end
				any_clip = any_clip | over;
			end
			coinc_f <= coinc_s[Steps];
			clip_f  <= any_clip & ~coinc_s[Steps];
		end
	end

	assign out_valid = v_f;
	assign out_force = force_f;
	assign out_coinc = coinc_f;
	assign out_clip  = clip_f;

endmodule
